// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL: clocked, reset-gated properties.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, ignored while reset is high.
`define CSP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("profiler assertion failed");

// Property checked at every rising edge, including during reset.
`define CSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("profiler assertion failed");

`endif

// ===== rtl/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// csp_pkg
// Types and constants of the checkpoint section profiler.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam logic [23:0] CNT24_MAX = 24'hFF_FFFF;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_MARK = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // One checkpoint record: 368 bits.
  typedef struct packed {
    logic [31:0] run;
    logic [23:0] dcount;
    logic [63:0] dsum;
    logic [31:0] dmean;
    logic [31:0] dmin;
    logic [31:0] dmax;
    logic [15:0] llast;
    logic [23:0] lcount;
    logic [63:0] lsum;
    logic [15:0] lmean;
    logic [15:0] lmin;
    logic [15:0] lmax;
  } slot_t;

endpackage

// ===== rtl/checkpoint_section_profiler.sv =====
// A mark to checkpoint 0 that closes a section also copies all SLOT_COUNT slots
// into the snapshot table, after recording the scanline in the slot after the
// closed one when there is one; a read waits until the output register is free.
// Throughput: one request at a time; the shared divider (one quotient bit per
// cycle, 32 steps for a duration mean, 16 for a scanline mean) sets mark cost.
// Reset: synchronous, clears control, valid bits of both tables at once, so
// no clearing pass is needed; the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
// checkpoint_section_profiler
// Section profiler over a table of checkpoints with a published snapshot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module checkpoint_section_profiler
  import csp_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [3:0]  slot_index,
  input  logic [15:0] scanline_now,
  input  logic [15:0] tick_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  entry_number,
  output logic        from_snapshot,
  output logic [31:0] duration_running,
  output logic [23:0] duration_count,
  output logic [31:0] duration_mean,
  output logic [31:0] duration_least,
  output logic [31:0] duration_most,
  output logic [15:0] line_latest,
  output logic [23:0] line_count,
  output logic [15:0] line_mean,
  output logic [15:0] line_least,
  output logic [15:0] line_most
);

  localparam int ADDR_W = $clog2(SLOT_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_LATCH, S_UPD, S_DINIT, S_DIV, S_WB,
    S_SNAP_RD, S_SNAP_WR, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_TICK, PH_CLOSE, PH_NOTE_NEXT, PH_NOTE_IDX, PH_READ
  } phase_t;

  state_t state;
  phase_t phase;

  // Configuration and profiling control.
  logic              profiling_enabled;
  logic              active_valid;
  logic [ADDR_W-1:0] active_slot;
  logic              snapshot_present;

  // Request held during the sequence.
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] mark_idx;
  logic              mark_zero;
  logic [15:0]       line_reg;
  logic [15:0]       tick_reg;
  logic              read_snap;
  logic [3:0]        read_idx;

  // Working record and the two tables with per-slot valid bits.
  slot_t             work;
  slot_t             upd;
  slot_t             live_mem [SLOT_COUNT];
  slot_t             snap_mem [SLOT_COUNT];
  slot_t             live_q;
  slot_t             snap_q;
  logic [SLOT_COUNT-1:0] live_vld;
  logic [SLOT_COUNT-1:0] snap_vld;
  logic              live_vq;
  logic              snap_vq;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] snap_cnt;

  // Shared divider.
  logic              div_line;
  logic [23:0]       div_rem;
  logic [23:0]       div_dvs;
  logic [31:0]       div_low;
  logic [31:0]       div_quo;
  logic [5:0]        div_cnt;
  logic [24:0]       div_trial;
  logic              div_ge;
  logic [47:0]       dinit_hi;

  logic              idx_ok;
  logic [ADDR_W:0]   next_slot;
  logic              next_ok;
  logic              accept;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign idx_ok    = (32'(slot_index) < SLOT_COUNT);
  assign next_slot = {1'b0, active_slot} + (ADDR_W+1)'(1);
  assign next_ok   = (next_slot < (ADDR_W+1)'(SLOT_COUNT));
  assign rd_addr   = (state == S_SNAP_RD) ? snap_cnt : cur_addr;

  assign div_trial = {div_rem, div_low[31]};
  assign div_ge    = (div_trial >= {1'b0, div_dvs});
  assign dinit_hi  = div_line ? work.lsum[63:16] : {16'd0, work.dsum[63:32]};

  // Statistic update of the working record for the current phase.
  always_comb begin
    logic [32:0] run_sum;
    logic [64:0] dsum_sum;
    logic [64:0] lsum_sum;
    upd      = work;
    run_sum  = {1'b0, work.run} + {17'd0, tick_reg};
    dsum_sum = {1'b0, work.dsum} + {33'd0, work.run};
    lsum_sum = {1'b0, work.lsum} + {49'd0, line_reg};
    unique case (phase)
      PH_TICK: begin
        upd.run = run_sum[32] ? '1 : run_sum[31:0];
      end
      PH_CLOSE: begin
        if (work.dcount == '0) begin
          upd.dmin = work.run;
          upd.dmax = work.run;
        end else begin
          if (work.run < work.dmin) upd.dmin = work.run;
          if (work.run > work.dmax) upd.dmax = work.run;
        end
        if (work.dcount != CNT24_MAX) upd.dcount = work.dcount + 24'd1;
        upd.dsum = dsum_sum[64] ? '1 : dsum_sum[63:0];
        upd.run  = '0;
      end
      PH_NOTE_NEXT, PH_NOTE_IDX: begin
        if (work.lcount == '0) begin
          upd.lmin = line_reg;
          upd.lmax = line_reg;
        end else begin
          if (line_reg < work.lmin) upd.lmin = line_reg;
          if (line_reg > work.lmax) upd.lmax = line_reg;
        end
        if (work.lcount != CNT24_MAX) upd.lcount = work.lcount + 24'd1;
        upd.llast = line_reg;
        upd.lsum  = lsum_sum[64] ? '1 : lsum_sum[63:0];
        if (phase == PH_NOTE_IDX) upd.run = '0;
      end
      default: begin
        upd = work;
      end
    endcase
  end

  // Table storage with registered reads.
  always_ff @(posedge clk) begin
    live_q  <= live_mem[rd_addr];
    snap_q  <= snap_mem[rd_addr];
    live_vq <= live_vld[rd_addr];
    snap_vq <= snap_vld[rd_addr];
    if (state == S_WB) live_mem[cur_addr] <= work;
    if (state == S_SNAP_WR) snap_mem[snap_cnt] <= live_q;
  end

  // Sequencer, control state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      phase             <= PH_TICK;
      profiling_enabled <= 1'b0;
      active_valid      <= 1'b0;
      active_slot       <= '0;
      snapshot_present  <= 1'b0;
      live_vld          <= '0;
      snap_vld          <= '0;
      out_valid         <= 1'b0;
      snap_cnt          <= '0;
      div_cnt           <= '0;
    end else begin
      // The output stage reloads the register itself when it is drained.
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      if (cfg_we) begin
        profiling_enabled <= cfg_wdata;
        if (!cfg_wdata) begin
          active_valid <= 1'b0;
          active_slot  <= '0;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            line_reg  <= scanline_now;
            tick_reg  <= tick_amount;
            read_snap <= snapshot_present;
            read_idx  <= slot_index;
            mark_idx  <= ADDR_W'(slot_index);
            mark_zero <= (slot_index == 4'd0);
            case (action)
              ACT_TICK: begin
                if (profiling_enabled && active_valid) begin
                  phase    <= PH_TICK;
                  cur_addr <= active_slot;
                  state    <= S_FETCH;
                end
              end
              ACT_MARK: begin
                if (profiling_enabled && idx_ok) begin
                  state <= S_FETCH;
                  if (active_valid) begin
                    phase    <= PH_CLOSE;
                    cur_addr <= active_slot;
                  end else begin
                    phase    <= PH_NOTE_IDX;
                    cur_addr <= ADDR_W'(slot_index);
                  end
                end
              end
              ACT_READ: begin
                if (idx_ok) begin
                  phase    <= PH_READ;
                  cur_addr <= ADDR_W'(slot_index);
                  state    <= S_FETCH;
                end else begin
                  work  <= '0;
                  state <= S_OUT;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          if (phase == PH_READ && read_snap) begin
            work <= snap_vq ? snap_q : '0;
          end else begin
            work <= live_vq ? live_q : '0;
          end
          state <= (phase == PH_READ) ? S_OUT : S_UPD;
        end
        S_UPD: begin
          work     <= upd;
          div_line <= (phase != PH_CLOSE);
          state    <= (phase == PH_TICK) ? S_WB : S_DINIT;
        end
        S_DINIT: begin
          if (dinit_hi >= {24'd0, (div_line ? work.lcount : work.dcount)}) begin
            // Quotient does not fit the mean field: clamp.
            div_quo <= '1;
            div_cnt <= '0;
            state   <= S_WB;
            if (div_line) work.lmean <= '1;
            else work.dmean <= '1;
          end else begin
            if (div_line) begin
              div_dvs <= work.lcount;
              div_low <= {work.lsum[15:0], 16'd0};
              div_cnt <= 6'd16;
            end else begin
              div_dvs <= work.dcount;
              div_low <= work.dsum[31:0];
              div_cnt <= 6'd32;
            end
            div_rem <= dinit_hi[23:0];
            div_quo <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem <= div_ge ? 24'(div_trial - {1'b0, div_dvs}) : div_trial[23:0];
          div_low <= {div_low[30:0], 1'b0};
          div_quo <= {div_quo[30:0], div_ge};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) begin
            state <= S_WB;
            if (div_line) work.lmean <= {div_quo[14:0], div_ge};
            else work.dmean <= {div_quo[30:0], div_ge};
          end
        end
        S_WB: begin
          live_vld[cur_addr] <= 1'b1;
          unique case (phase)
            PH_CLOSE: begin
              if (mark_zero && next_ok) begin
                phase    <= PH_NOTE_NEXT;
                cur_addr <= next_slot[ADDR_W-1:0];
                state    <= S_FETCH;
              end else if (mark_zero) begin
                snap_cnt <= '0;
                state    <= S_SNAP_RD;
              end else begin
                phase    <= PH_NOTE_IDX;
                cur_addr <= mark_idx;
                state    <= S_FETCH;
              end
            end
            PH_NOTE_NEXT: begin
              snap_cnt <= '0;
              state    <= S_SNAP_RD;
            end
            PH_NOTE_IDX: begin
              active_slot  <= mark_idx;
              active_valid <= 1'b1;
              state        <= S_IDLE;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_SNAP_RD: begin
          state <= S_SNAP_WR;
        end
        S_SNAP_WR: begin
          snap_vld[snap_cnt] <= live_vq;
          snap_cnt           <= snap_cnt + ADDR_W'(1);
          if (snap_cnt == ADDR_W'(SLOT_COUNT - 1)) begin
            snapshot_present <= 1'b1;
            phase            <= PH_NOTE_IDX;
            cur_addr         <= mark_idx;
            state            <= S_FETCH;
          end else begin
            state <= S_SNAP_RD;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            entry_number     <= read_idx;
            from_snapshot    <= read_snap;
            duration_running <= work.run;
            duration_count   <= work.dcount;
            duration_mean    <= work.dmean;
            duration_least   <= work.dmin;
            duration_most    <= work.dmax;
            line_latest      <= work.llast;
            line_count       <= work.lcount;
            line_mean        <= work.lmean;
            line_least       <= work.lmin;
            line_most        <= work.lmax;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CSP_ASSERT(a_snap_sticky, clk, rst, snapshot_present |=> snapshot_present)
  `CSP_ASSERT(a_active_needs_en, clk, rst, active_valid |-> profiling_enabled)
  `CSP_ASSERT(a_div_count_live, clk, rst, (state == S_DIV) |-> (div_cnt != 6'd0))
  `CSP_ASSERT(a_read_busy, clk, rst, (accept && action == ACT_READ) |=> (state != S_IDLE))

endmodule

// ===== dv/checkpoint_section_profiler_checker.sv =====
// ----------------------------------------------------------------------------
// checkpoint_section_profiler_checker
// Watches the request, response and configuration ports of the profiler,
// keeps its own copy of the checkpoint tables and compares every response.
// ----------------------------------------------------------------------------
module checkpoint_section_profiler_checker
  import csp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [3:0]  slot_index,
  input  logic [15:0] scanline_now,
  input  logic [15:0] tick_amount,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  entry_number,
  input  logic        from_snapshot,
  input  logic [31:0] duration_running,
  input  logic [23:0] duration_count,
  input  logic [31:0] duration_mean,
  input  logic [31:0] duration_least,
  input  logic [31:0] duration_most,
  input  logic [15:0] line_latest,
  input  logic [23:0] line_count,
  input  logic [15:0] line_mean,
  input  logic [15:0] line_least,
  input  logic [15:0] line_most,
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = SLOT_COUNT_DEF;

  typedef struct packed {
    logic [3:0]  entry;
    logic        snap;
    logic [31:0] run;
    logic [23:0] dcount;
    logic [31:0] dmean;
    logic [31:0] dmin;
    logic [31:0] dmax;
    logic [15:0] llast;
    logic [23:0] lcount;
    logic [15:0] lmean;
    logic [15:0] lmin;
    logic [15:0] lmax;
  } readout_t;

  slot_t      live_tab [SLOTS];
  slot_t      snap_tab [SLOTS];
  logic [3:0] cur_slot;
  logic       cur_open;
  logic       have_snap;
  logic       enabled;
  readout_t   readouts [$];

  function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[64] ? '1 : t[63:0];
  endfunction

  function automatic slot_t add_scanline(slot_t e, logic [15:0] line);
    logic [63:0] q;
    if (e.lcount == 0) begin
      e.lmin = line;
      e.lmax = line;
    end else begin
      if (line < e.lmin) e.lmin = line;
      if (line > e.lmax) e.lmax = line;
    end
    if (e.lcount != CNT24_MAX) e.lcount = e.lcount + 24'd1;
    e.llast = line;
    e.lsum = sum_sat(e.lsum, {48'd0, line});
    q = e.lsum / {40'd0, e.lcount};
    e.lmean = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
    return e;
  endfunction

  function automatic slot_t close_duration(slot_t e);
    logic [63:0] q;
    if (e.dcount == 0) begin
      e.dmin = e.run;
      e.dmax = e.run;
    end else begin
      if (e.run < e.dmin) e.dmin = e.run;
      if (e.run > e.dmax) e.dmax = e.run;
    end
    if (e.dcount != CNT24_MAX) e.dcount = e.dcount + 24'd1;
    e.dsum = sum_sat(e.dsum, {32'd0, e.run});
    q = e.dsum / {40'd0, e.dcount};
    e.dmean = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    e.run = 0;
    return e;
  endfunction

  always @(posedge clk) begin
    readout_t got;
    readout_t want;
    slot_t    e;
    logic [32:0] r;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        live_tab[i] = '0;
        snap_tab[i] = '0;
      end
      cur_slot = 0;
      cur_open = 0;
      have_snap = 0;
      enabled = 0;
      readouts.delete();
      failures <= 0;
    end else begin
      // Responses are checked before this edge's request is folded in.
      if (out_valid && out_ready) begin
        got = '{entry_number, from_snapshot, duration_running, duration_count,
                duration_mean, duration_least, duration_most, line_latest,
                line_count, line_mean, line_least, line_most};
        if (readouts.size() == 0) begin
          if (failures < 10) $display("unexpected response %p", got);
          failures <= failures + 1;
        end else begin
          want = readouts.pop_front();
          if (got !== want) begin
            if (failures < 10) $display("mismatch: expected %p, actual %p", want, got);
            failures <= failures + 1;
          end
        end
      end
      if (cfg_we) begin
        enabled = cfg_wdata;
        if (!cfg_wdata) begin
          cur_open = 0;
          cur_slot = 0;
        end
      end
      if (in_valid && in_ready) begin
        case (action)
          ACT_TICK: begin
            if (enabled && cur_open) begin
              r = {1'b0, live_tab[cur_slot].run} + {17'd0, tick_amount};
              live_tab[cur_slot].run = r[32] ? 32'hFFFF_FFFF : r[31:0];
            end
          end
          ACT_MARK: begin
            if (enabled) begin
              if (cur_open) begin
                live_tab[cur_slot] = close_duration(live_tab[cur_slot]);
                if (slot_index == 0) begin
                  if (cur_slot != SLOTS - 1)
                    live_tab[cur_slot + 1] = add_scanline(live_tab[cur_slot + 1], scanline_now);
                  snap_tab = live_tab;
                  have_snap = 1;
                end
              end
              live_tab[slot_index] = add_scanline(live_tab[slot_index], scanline_now);
              live_tab[slot_index].run = 0;
              cur_slot = slot_index;
              cur_open = 1;
            end
          end
          ACT_READ: begin
            e = have_snap ? snap_tab[slot_index] : live_tab[slot_index];
            want = '{slot_index, have_snap, e.run, e.dcount, e.dmean, e.dmin, e.dmax,
                     e.llast, e.lcount, e.lmean, e.lmin, e.lmax};
            readouts.push_back(want);
          end
          default: ;
        endcase
      end
    end
    pending <= readouts.size();
  end

endmodule

// ===== dv/checkpoint_section_profiler_test.sv =====
// ----------------------------------------------------------------------------
// checkpoint_section_profiler_test
// Drives ticks, marks, reads and unused codes into the profiler over several
// enable settings, randomly idling both channels; the checker judges results.
// ----------------------------------------------------------------------------
module checkpoint_section_profiler_test
  import csp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Code with no meaning to the block; it must be dropped without a response.
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 800000;
  // Quiet time that covers a mark to checkpoint 0 with the snapshot copy.
  localparam int SETTLE = 250;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0]  action = ACT_TICK;
  logic [3:0]  slot_index = 0;
  logic [15:0] scanline_now = 0;
  logic [15:0] tick_amount = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [3:0]  entry_number;
  logic        from_snapshot;
  logic [31:0] duration_running, duration_mean, duration_least, duration_most;
  logic [23:0] duration_count, line_count;
  logic [15:0] line_latest, line_mean, line_least, line_most;

  int failures;
  int pending;
  int cycles = 0;
  logic in_taken = 0;
  // While set, neither side idles.
  logic steady = 0;
  // Next checkpoint in the well-formed frame sequence.
  logic [3:0] frame_cursor = 0;

  always #1 clk = ~clk;

  checkpoint_section_profiler DUT (.*);

  checkpoint_section_profiler_checker scoreboard (.*);

  // Registered record of an accepted request, read safely at the falling edge.
  always @(posedge clk) in_taken <= in_valid && in_ready;

  // Response side stalls about 13 times in a hundred.
  always @(negedge clk) begin
    out_ready <= rst ? 1'b0 : (steady || $urandom_range(99) >= 13);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("checkpoint_section_profiler_test: errors");
      $finish;
    end
  end

  // Presents one request at a falling edge and holds it until accepted.
  task automatic send_request(logic [1:0] act, logic [3:0] idx,
                              logic [15:0] line, logic [15:0] tick);
    if (!steady && $urandom_range(99) < 13) begin
      in_valid <= 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1;
    action <= act;
    slot_index <= idx;
    scanline_now <= line;
    tick_amount <= tick;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
  endtask

  // Writes the enable register once the block has gone quiet.
  task automatic write_enable(logic value);
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly frame-ordered marks with ticks between, plus reads and noise.
  task automatic random_request();
    int roll;
    logic [3:0] idx;
    roll = $urandom_range(99);
    if (roll < 45) begin
      send_request(ACT_TICK, 4'($urandom), pick16(), pick16());
    end else if (roll < 70) begin
      if ($urandom_range(9) < 8) begin
        idx = frame_cursor;
        frame_cursor = ($urandom_range(5) == 0) ? 4'd0 : frame_cursor + 4'd1;
      end else begin
        idx = 4'($urandom);
      end
      send_request(ACT_MARK, idx, pick16(), pick16());
    end else if (roll < 95) begin
      send_request(ACT_READ, 4'($urandom), pick16(), pick16());
    end else begin
      send_request(ACT_NONE, 4'($urandom), pick16(), pick16());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Disabled after reset: reads give the cleared table, ticks and marks drop.
    send_request(ACT_READ, 4'd0, 16'h0, 16'h0);
    send_request(ACT_TICK, 4'd0, 16'h0, 16'hFFFF);
    send_request(ACT_MARK, 4'd3, 16'h1234, 16'h0);
    send_request(ACT_READ, 4'd3, 16'h0, 16'h0);
    send_request(ACT_READ, 4'd15, 16'hFFFF, 16'hFFFF);
    write_enable(1);

    // A tick and a mark to checkpoint 0 with nothing open change nothing
    // beyond the new slot.
    send_request(ACT_TICK, 4'd0, 16'h0, 16'h0100);
    send_request(ACT_MARK, 4'd0, 16'h0010, 16'h0);
    send_request(ACT_READ, 4'd0, 16'h0, 16'h0);
    send_request(ACT_MARK, 4'd15, 16'hFFFF, 16'h0);
    send_request(ACT_TICK, 4'd0, 16'h0, 16'hFFFF);
    send_request(ACT_TICK, 4'd0, 16'h0, 16'hFFFF);
    send_request(ACT_TICK, 4'd0, 16'h0, 16'h0000);
    send_request(ACT_READ, 4'd15, 16'h0, 16'h0);
    // Closing the last slot: snapshot taken, no slot after it to record.
    send_request(ACT_MARK, 4'd0, 16'h0000, 16'h0);
    send_request(ACT_READ, 4'd15, 16'h0, 16'h0);
    send_request(ACT_NONE, 4'd2, 16'hFFFF, 16'hFFFF);
    send_request(ACT_MARK, 4'd5, 16'd100, 16'h0);
    send_request(ACT_TICK, 4'd0, 16'h0, 16'd7);
    // Back to checkpoint 0 from slot 5: slot 6 gets the scanline too.
    send_request(ACT_MARK, 4'd0, 16'd200, 16'h0);
    send_request(ACT_READ, 4'd6, 16'h0, 16'h0);
    send_request(ACT_READ, 4'd5, 16'h0, 16'h0);
    write_enable(0);
    send_request(ACT_TICK, 4'd0, 16'h0, 16'h0040);
    send_request(ACT_READ, 4'd5, 16'h0, 16'h0);
    write_enable(1);

    // Random phases over several settings; the first one runs without idling.
    for (int phase = 0; phase < 4; phase++) begin
      steady = (phase == 0);
      frame_cursor = 0;
      repeat (phase == 1 ? 120 : 320) random_request();
      steady = 0;
      write_enable(phase == 0 ? 1'b0 : 1'b1);
    end
    repeat (20) random_request();

    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("checkpoint_section_profiler_test: clean");
    end else begin
      $display("checkpoint_section_profiler_test: errors");
    end
    $finish;
  end

endmodule
